[rtl/core/assert_macros.svh]
// assertion helpers shared by the core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside reset
`define FPS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define FPS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/core/fpsamp_pkg.sv]
package fpsamp_pkg;

   // default sizing
   localparam int DEF_MAX_POINTS  = 1024;
   localparam int DEF_COORD_WIDTH = 16;

   // register and result fields
   localparam int SAMPLE_W      = 7;
   localparam int INDEX_W       = 10;
   localparam int RSP_TDATA_W   = 16;
   localparam logic [SAMPLE_W-1:0] MAX_PICKS    = 7'd64;
   localparam logic [SAMPLE_W-1:0] SAMPLE_RESET = 7'd16;

   // classification of one queued item
   typedef struct packed {
      logic store;   // point fits in the store
      logic last;    // final point of the cloud
   } flag_type;

   localparam int FLAG_W = $bits(flag_type);

endpackage

[rtl/core/farthest_point_sampler_core.sv]
// farthest point sampler
// req channel: one point per transfer, x/y/z packed in req_tdata, req_tlast on the
// final point of a cloud. Points past MAX_POINTS are dropped; a tlast on a dropped
// point still closes the cloud.
// rsp channel: sample_count transfers per cloud, the sample index in rsp_tdata and
// rsp_tlast on the final one. The first sample is the point with the largest x,
// each further one the point farthest from the samples so far, ties to the lowest
// index.
// csr port: csr_we writes sample_count (0 acts as 1, above 64 acts as 64); the
// user must write it only while the core is idle; the core itself has no check.
// timing: loading takes one cycle per point through a four-entry queue while the
// sequencer is idle. After the last point, each sweep walks every stored point
// once through the point and distance memories at one point per cycle, then reads
// back the next pick. The first sample passes ST_START, ST_RDB and ST_CAPB into
// the output register after the closing point leaves the queue.
// a stalled rsp holds the sequencer at its next result; the queue fills and then
// req_tready drops. Reset empties the queue, the cloud and the output register and
// sets sample_count to 16.
module farthest_point_sampler_core #(
   parameter int MAX_POINTS  = fpsamp_pkg::DEF_MAX_POINTS,
   parameter int COORD_WIDTH = fpsamp_pkg::DEF_COORD_WIDTH
) (
   input  logic clock,
   input  logic reset,
   // coord_x, coord_y, coord_z from bit 0 up, zero padded to bytes
   input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic                               req_tlast,
   // sample_index in the low bits, zero padded
   output logic [fpsamp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [fpsamp_pkg::SAMPLE_W-1:0]    csr_wdata
);
   import fpsamp_pkg::*;

   localparam int PW = 3*COORD_WIDTH;
   localparam int QW = PW + FLAG_W;

   logic [SAMPLE_W-1:0] sample_count_ff;
   logic                q_push, q_full, q_pop, q_valid;
   logic [PW-1:0]       q_coords_in;
   flag_type            q_flags_in, q_flags_out;
   logic [QW-1:0]       q_out;
   logic [INDEX_W-1:0]  out_index;

   // sample count register
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= SAMPLE_RESET;
      end else if (csr_we) begin
         sample_count_ff <= csr_wdata;
      end
   end

   fpsamp_front #(
      .MAX_POINTS  (MAX_POINTS),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_coords (req_tdata[PW-1:0]),
      .in_last   (req_tlast),
      .q_push    (q_push),
      .q_coords  (q_coords_in),
      .q_flags   (q_flags_in),
      .q_full    (q_full)
   );

   fpsamp_fifo #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({q_flags_in, q_coords_in}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .not_empty (q_valid)
   );

   assign q_flags_out = q_out[QW-1:PW];

   fpsamp_engine #(
      .MAX_POINTS  (MAX_POINTS),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .sample_count (sample_count_ff),
      .q_valid      (q_valid),
      .q_pop        (q_pop),
      .q_coords     (q_out[PW-1:0]),
      .q_flags      (q_flags_out),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_index    (out_index),
      .out_last     (rsp_tlast)
   );

   assign rsp_tdata = RSP_TDATA_W'(out_index);

endmodule

[rtl/core/fpsamp_fifo.sv]
module fpsamp_fifo #(
   parameter int WIDTH = 50
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);
   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   assign full      = (count_ff == (PTR_W+1)'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff + (push ? 1'b1 : 1'b0);
      rd_ptr_in = rd_ptr_ff + (pop ? 1'b1 : 1'b0);
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/fpsamp_front.sv]
module fpsamp_front #(
   parameter int MAX_POINTS  = fpsamp_pkg::DEF_MAX_POINTS,
   parameter int COORD_WIDTH = fpsamp_pkg::DEF_COORD_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [3*COORD_WIDTH-1:0]   in_coords,
   input  logic                       in_last,
   output logic                       q_push,
   output logic [3*COORD_WIDTH-1:0]   q_coords,
   output fpsamp_pkg::flag_type       q_flags,
   input  logic                       q_full
);
   import fpsamp_pkg::*;

   localparam int CNT_W = $clog2(MAX_POINTS) + 1;

   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             xfer;

   assign in_ready = !q_full;
   assign xfer     = in_valid && !q_full;

   // classify: store while there is room, mark the cloud end
   always_comb begin
      q_push        = xfer;
      q_coords      = in_coords;
      q_flags.store = (fill_ff < CNT_W'(MAX_POINTS));
      q_flags.last  = in_last;
      fill_in       = fill_ff;
      if (xfer) begin
         if (in_last) begin
            fill_in = '0;
         end else if (q_flags.store) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

endmodule

[rtl/core/fpsamp_engine.sv]
module fpsamp_engine #(
   parameter int MAX_POINTS  = fpsamp_pkg::DEF_MAX_POINTS,
   parameter int COORD_WIDTH = fpsamp_pkg::DEF_COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [fpsamp_pkg::SAMPLE_W-1:0] sample_count,
   input  logic                          q_valid,
   output logic                          q_pop,
   input  logic [3*COORD_WIDTH-1:0]      q_coords,
   input  fpsamp_pkg::flag_type          q_flags,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [fpsamp_pkg::INDEX_W-1:0] out_index,
   output logic                          out_last
);
   import fpsamp_pkg::*;

   localparam int CW    = COORD_WIDTH;
   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = IDX_W + 1;
   localparam int DW    = 2*CW + 2;
   localparam int PW    = 3*CW;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_START = 3'd1;
   localparam logic [2:0] ST_RDB   = 3'd2;
   localparam logic [2:0] ST_CAPB  = 3'd3;
   localparam logic [2:0] ST_SCAN  = 3'd4;
   localparam logic [2:0] ST_DRAIN = 3'd5;

   logic [PW-1:0]  pt_mem   [MAX_POINTS];
   logic [DW-1:0]  dist_mem [MAX_POINTS];

   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [IDX_W-1:0]    j_ff, j_in;
   logic [IDX_W-1:0]    bestx_ff, bestx_in;
   logic signed [CW-1:0] maxx_ff, maxx_in;
   logic [IDX_W-1:0]    best_ff, best_in;
   logic [SAMPLE_W-1:0] picks_ff, picks_in, pick_ff, pick_in;
   logic                first_ff, first_in;
   logic [PW-1:0]       bp_ff, bp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [IDX_W-1:0]    rd_addr;
   logic [PW-1:0]       rd_pt_ff;
   logic [DW-1:0]       rd_dist_ff;

   logic                s1_valid_ff, s1_valid_in;
   logic [IDX_W-1:0]    s1_idx_ff;
   logic                s2_valid_ff;
   logic [IDX_W-1:0]    s2_idx_ff;
   logic [DW-1:0]       s2_old_ff;
   logic [DW-1:0]       s2_p0_ff, s2_p1_ff, s2_p2_ff;
   logic [DW-1:0]       far_ff, far_in;
   logic [IDX_W-1:0]    far_idx_ff, far_idx_in;

   logic signed [CW:0]  d0, d1, d2;
   logic signed [DW-1:0] sq0, sq1, sq2;
   logic [DW-1:0]       sum, new_min;
   logic                last_pick, out_free, x_new_max;
   logic [SAMPLE_W-1:0] picks_clamp;

   assign out_valid = rsp_valid_ff;
   assign out_index = rsp_index_ff;
   assign out_last  = rsp_last_ff;
   assign out_free  = !rsp_valid_ff || out_ready;
   assign last_pick = ((pick_ff + 1'b1) == picks_ff);

   // picks per cloud, zero taken as one, saturated at the limit
   always_comb begin
      picks_clamp = sample_count;
      if (sample_count == '0) begin
         picks_clamp = SAMPLE_W'(1);
      end else if (sample_count > MAX_PICKS) begin
         picks_clamp = MAX_PICKS;
      end
   end

   // largest x so far, lowest index on ties
   assign x_new_max = (n_ff == '0) ||
                      ($signed(q_coords[CW-1:0]) > maxx_ff);

   // sequencer: load, then per pick read the pick, emit it, sweep the points
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      j_in         = j_ff;
      bestx_in     = bestx_ff;
      maxx_in      = maxx_ff;
      best_in      = best_ff;
      picks_in     = picks_ff;
      pick_in      = pick_ff;
      first_in     = first_ff;
      bp_in        = bp_ff;
      rsp_valid_in = rsp_valid_ff && !out_ready;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      s1_valid_in  = 1'b0;
      rd_addr      = best_ff;
      q_pop        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_flags.store) begin
                  n_in = n_ff + 1'b1;
                  if (x_new_max) begin
                     maxx_in  = $signed(q_coords[CW-1:0]);
                     bestx_in = n_ff[IDX_W-1:0];
                  end
               end
               if (q_flags.last) begin
                  picks_in = picks_clamp;
                  pick_in  = '0;
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            best_in  = bestx_ff;
            first_in = 1'b1;
            state_in = ST_RDB;
         end
         ST_RDB: begin
            state_in = ST_CAPB;
         end
         ST_CAPB: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = INDEX_W'(best_ff);
               rsp_last_in  = last_pick;
               if (last_pick) begin
                  n_in     = '0;
                  state_in = ST_IDLE;
               end else begin
                  bp_in    = rd_pt_ff;
                  pick_in  = pick_ff + 1'b1;
                  j_in     = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_addr     = j_ff;
            s1_valid_in = 1'b1;
            j_in        = j_ff + 1'b1;
            if (CNT_W'(j_ff) == n_ff - 1'b1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_valid_ff && !s2_valid_ff) begin
               first_in = 1'b0;
               best_in  = far_idx_ff;
               state_in = ST_RDB;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         n_ff         <= '0;
         pick_ff      <= '0;
         picks_ff     <= SAMPLE_W'(1);
         rsp_valid_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         pick_ff      <= pick_in;
         picks_ff     <= picks_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      j_ff         <= j_in;
      bestx_ff     <= bestx_in;
      maxx_ff      <= maxx_in;
      best_ff      <= best_in;
      first_ff     <= first_in;
      bp_ff        <= bp_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
      far_ff       <= far_in;
      far_idx_ff   <= far_idx_in;
   end

   // point store: loaded from the queue, read for the pick and the sweep
   always_ff @(posedge clock) begin
      if (q_pop && q_flags.store) begin
         pt_mem[n_ff[IDX_W-1:0]] <= q_coords;
      end
      rd_pt_ff <= pt_mem[rd_addr];
   end

   // sweep stage one: coordinate differences squared
   always_comb begin
      d0  = $signed({rd_pt_ff[CW-1], rd_pt_ff[CW-1:0]})
          - $signed({bp_ff[CW-1], bp_ff[CW-1:0]});
      d1  = $signed({rd_pt_ff[2*CW-1], rd_pt_ff[2*CW-1:CW]})
          - $signed({bp_ff[2*CW-1], bp_ff[2*CW-1:CW]});
      d2  = $signed({rd_pt_ff[3*CW-1], rd_pt_ff[3*CW-1:2*CW]})
          - $signed({bp_ff[3*CW-1], bp_ff[3*CW-1:2*CW]});
      sq0 = d0 * d0;
      sq1 = d1 * d1;
      sq2 = d2 * d2;
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= rd_addr;
      s2_idx_ff <= s1_idx_ff;
      s2_p0_ff  <= sq0;
      s2_p1_ff  <= sq1;
      s2_p2_ff  <= sq2;
      s2_old_ff <= first_ff ? {DW{1'b1}} : rd_dist_ff;
   end

   // sweep stage two: lower the running minimum, track the farthest point
   always_comb begin
      sum        = s2_p0_ff + s2_p1_ff + s2_p2_ff;
      new_min    = (sum < s2_old_ff) ? sum : s2_old_ff;
      far_in     = far_ff;
      far_idx_in = far_idx_ff;
      if (s2_valid_ff && ((s2_idx_ff == '0) || (new_min > far_ff))) begin
         far_in     = new_min;
         far_idx_in = s2_idx_ff;
      end
   end

   // minimum distance store, first sweep of a cloud reads as all ones
   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         dist_mem[s2_idx_ff] <= new_min;
      end
      rd_dist_ff <= dist_mem[rd_addr];
   end

   `include "assert_macros.svh"

   `FPS_ASSERT(a_pick_bound, (state_ff != ST_IDLE) |-> (pick_ff < picks_ff), "pick past count")
   `FPS_ASSERT(a_scan_bound, (state_ff == ST_SCAN) |-> (CNT_W'(j_ff) < n_ff), "scan past cloud")
   `FPS_ASSERT(a_pipe_idle, (state_ff == ST_IDLE) |-> (!s1_valid_ff && !s2_valid_ff), "sweep busy in idle")
   `FPS_ASSERT(a_emit_last, (rsp_valid_in && !(rsp_valid_ff && !out_ready) && rsp_last_in) |=> (state_ff == ST_IDLE), "last pick not ending cloud")
   `FPS_ASSERT_ALWAYS(a_reset_clear, reset |=> !rsp_valid_ff, "result valid after reset")

endmodule

[tb/sv/farthest_point_sampler_core_tb.sv]
module farthest_point_sampler_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fpsamp_pkg::*;

   localparam int NPTS  = 1024;
   localparam int CW    = 16;
   localparam int REQ_W = ((3*CW+7)/8)*8;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic               last;
   } sample_type;

   // expected samples and the cloud model that produces them
   class sample_scoreboard;
      int                 px[$], py[$], pz[$];
      logic [33:0]        min_dist[NPTS];
      logic [SAMPLE_W-1:0] picks_cfg;
      sample_type         pending[$];
      int                 errors;

      function new();
         picks_cfg = SAMPLE_RESET;
         errors = 0;
      endfunction

      function logic [33:0] sq_dist(int a, int b);
         longint dx, dy, dz;
         dx = px[a] - px[b];
         dy = py[a] - py[b];
         dz = pz[a] - pz[b];
         return 34'(dx*dx + dy*dy + dz*dz);
      endfunction

      // note one accepted point transfer
      function void note_point(logic [REQ_W-1:0] data, logic tlast);
         int n, picks, best;
         sample_type s;
         if (px.size() < NPTS) begin
            px.push_back(int'($signed(data[CW-1:0])));
            py.push_back(int'($signed(data[2*CW-1:CW])));
            pz.push_back(int'($signed(data[3*CW-1:2*CW])));
         end
         if (!tlast) return;
         n = px.size();
         picks = picks_cfg;
         if (picks == 0) picks = 1;
         if (picks > MAX_PICKS) picks = MAX_PICKS;
         best = 0;
         for (int j = 0; j < n; j++) begin
            min_dist[j] = '1;
            if (px[j] > px[best]) best = j;
         end
         for (int i = 0; i < picks; i++) begin
            s.index = best[INDEX_W-1:0];
            s.last = (i + 1 == picks);
            pending.push_back(s);
            for (int j = 0; j < n; j++)
               if (sq_dist(j, best) < min_dist[j]) min_dist[j] = sq_dist(j, best);
            best = 0;
            for (int j = 1; j < n; j++)
               if (min_dist[j] > min_dist[best]) best = j;
         end
         px.delete(); py.delete(); pz.delete();
      endfunction

      // compare one accepted sample transfer
      function void check_sample(logic [RSP_TDATA_W-1:0] data, logic tlast);
         sample_type s;
         if (pending.size() == 0) begin
            $error("unexpected sample index %0d", data[INDEX_W-1:0]);
            errors++;
            return;
         end
         s = pending.pop_front();
         if (data !== RSP_TDATA_W'(s.index)) begin
            $error("sample_index expected %0d actual %0d", s.index, data);
            errors++;
         end
         if (tlast !== s.last) begin
            $error("sample_last expected %0b actual %0b", s.last, tlast);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic [REQ_W-1:0] req_tdata;
   logic req_tvalid, req_tready, req_tlast;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic rsp_tvalid, rsp_tready, rsp_tlast;
   logic csr_we;
   logic [SAMPLE_W-1:0] csr_wdata;

   sample_scoreboard board = new();

   farthest_point_sampler_core dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("tb: failure");
      $finish;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // sample side: random backpressure, ready held low for a random gap
   initial begin
      int g;
      rsp_tready = 0;
      @(posedge clock iff !reset);
      forever begin
         g = gap_len();
         if (g > 0) begin
            rsp_tready <= 0;
            repeat (g) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) board.check_sample(rsp_tdata, rsp_tlast);
      end
   end

   task automatic send_point(int x, int y, int z, bit tlast, bit no_gap = 0);
      int g;
      g = no_gap ? 0 : gap_len();
      repeat (g) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tdata  <= {16'(z), 16'(y), 16'(x)};
      req_tlast  <= tlast;
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_point({16'(z), 16'(y), 16'(x)}, tlast);
   endtask

   task automatic idle_out();
      req_tvalid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_count(logic [SAMPLE_W-1:0] v);
      csr_wdata <= v;
      csr_we <= 1;
      @(posedge clock);
      csr_we <= 0;
      board.picks_cfg = v;
   endtask

   function automatic int rnd_coord();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 1) ? 32767 : -32768;
         1: return int'($urandom_range(0, 20)) - 10;
         default: return int'($signed(16'($urandom)));
      endcase
   endfunction

   task automatic send_cloud(int n);
      for (int i = 0; i < n; i++)
         send_point(rnd_coord(), rnd_coord(), rnd_coord(), i == n - 1);
   endtask

   int sent;

   initial begin
      reset = 1;
      req_tvalid = 0; req_tlast = 0; req_tdata = '0;
      csr_we = 0; csr_wdata = '0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: reset count on extremes, more picks than points
      send_point(-32768, 32767, -32768, 1'b0);
      send_point(32767, -32768, 32767, 1'b0);
      send_point(32767, 32767, 32767, 1'b0);
      send_point(0, 0, 0, 1'b1);
      idle_out();
      // single point cloud
      write_count(7'd1);
      send_point(5, -5, 5, 1'b1);
      idle_out();
      // zero and above-range counts
      write_count(7'd0);
      send_point(1, 2, 3, 1'b0);
      send_point(9, 2, 3, 1'b1);
      idle_out();
      write_count(7'd127);
      send_point(-1, -1, -1, 1'b0);
      send_point(-1, -1, -1, 1'b0);
      send_point(4, 4, 4, 1'b1);
      idle_out();
      write_count(7'd64);
      send_cloud(5);
      idle_out();
      // random clouds with random counts
      sent = 0;
      while (sent < 295) begin
         int n;
         write_count($urandom_range(0, 5) == 0 ? 7'($urandom_range(0, 127))
                                               : 7'($urandom_range(1, 64)));
         n = $urandom_range(1, 12) == 1 ? $urandom_range(30, 60) : $urandom_range(1, 10);
         send_cloud(n);
         sent += n;
         idle_out();
      end
      repeat (50) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule

[farthest_point_sampler_core.f]
+incdir+rtl/core
rtl/core/fpsamp_pkg.sv
rtl/core/fpsamp_fifo.sv
rtl/core/fpsamp_front.sv
rtl/core/fpsamp_engine.sv
rtl/core/farthest_point_sampler_core.sv
tb/sv/farthest_point_sampler_core_tb.sv
